// File: sv/hid_keyboard_report_to_ascii_macros.svh
// assertion macros for the checker
`ifndef HID_KEYBOARD_REPORT_TO_ASCII_MACROS_SVH
`define HID_KEYBOARD_REPORT_TO_ASCII_MACROS_SVH

// checked only out of reset
`define HKRA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HKRA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hkra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hkra_pkg;

  localparam int NUM_SLOTS       = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] KBD_TYPE   = 8'h06;
  localparam logic [7:0] KBD_LEN    = 8'h08;
  localparam logic [7:0] SHIFT_BITS = 8'h22;
  localparam logic [7:0] KC_A       = 8'h04;
  localparam logic [7:0] KC_Z       = 8'h1d;
  localparam logic [7:0] KC_BKSP    = 8'h2a;
  localparam logic [7:0] KC_CAPS    = 8'h39;
  localparam logic [7:0] KC_RIGHT   = 8'h4f;
  localparam logic [7:0] KC_LEFT    = 8'h50;
  localparam logic [7:0] KC_DOWN    = 8'h51;
  localparam logic [7:0] KC_UP      = 8'h52;
  localparam logic [7:0] PAD_FIRST  = 8'h54;
  localparam logic [7:0] PAD_LAST   = 8'h67;

  localparam logic [6:0] ASCII_BS      = 7'h08;
  localparam logic [6:0] ASCII_SP      = 7'h20;
  localparam logic [6:0] ASCII_ESC     = 7'h1b;
  localparam logic [6:0] ASCII_LBRACK  = 7'h5b;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_ARROW_R = 7'h43;
  localparam logic [6:0] ASCII_ARROW_L = 7'h44;
  localparam logic [6:0] ASCII_ARROW_D = 7'h42;
  localparam logic [6:0] ASCII_ARROW_U = 7'h41;

  localparam logic [1:0] SEQ_MID  = 2'd1;
  localparam logic [1:0] SEQ_LAST = 2'd2;

  typedef struct packed {
    logic [7:0] device_type;
    logic [7:0] report_length;
    logic [7:0] modifiers;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } report_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_report;
  } ascii_t;

  typedef enum logic [1:0] {
    TOK_NONE = 2'd0,
    TOK_CHAR = 2'd1,
    TOK_BS   = 2'd2,
    TOK_ESC  = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [6:0] ch;
  } slot_tok_t;

  typedef struct packed {
    slot_tok_t [NUM_SLOTS-1:0] toks;
  } entry_t;

  function automatic logic [6:0] plain_lookup(input logic [5:0] idx);
    logic [6:0] ch;
    case (idx)
      6'h1e: ch = 7'h31;
      6'h1f: ch = 7'h32;
      6'h20: ch = 7'h33;
      6'h21: ch = 7'h34;
      6'h22: ch = 7'h35;
      6'h23: ch = 7'h36;
      6'h24: ch = 7'h37;
      6'h25: ch = 7'h38;
      6'h26: ch = 7'h39;
      6'h27: ch = 7'h30;
      6'h28: ch = 7'h0a;
      6'h29: ch = 7'h1b;
      6'h2a: ch = 7'h08;
      6'h2b: ch = 7'h09;
      6'h2c: ch = 7'h20;
      6'h2d: ch = 7'h2d;
      6'h2e: ch = 7'h3d;
      6'h2f: ch = 7'h5b;
      6'h30: ch = 7'h5d;
      6'h31: ch = 7'h5c;
      6'h33: ch = 7'h3b;
      6'h34: ch = 7'h27;
      6'h35: ch = 7'h60;
      6'h36: ch = 7'h2c;
      6'h37: ch = 7'h2e;
      6'h38: ch = 7'h2f;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shift_lookup(input logic [5:0] idx);
    logic [6:0] ch;
    case (idx)
      6'h1e: ch = 7'h21;
      6'h1f: ch = 7'h40;
      6'h20: ch = 7'h23;
      6'h21: ch = 7'h24;
      6'h22: ch = 7'h25;
      6'h23: ch = 7'h5e;
      6'h24: ch = 7'h26;
      6'h25: ch = 7'h2a;
      6'h26: ch = 7'h28;
      6'h27: ch = 7'h29;
      6'h28: ch = 7'h0a;
      6'h29: ch = 7'h1b;
      6'h2a: ch = 7'h08;
      6'h2b: ch = 7'h09;
      6'h2c: ch = 7'h20;
      6'h2d: ch = 7'h5f;
      6'h2e: ch = 7'h2b;
      6'h2f: ch = 7'h7b;
      6'h30: ch = 7'h7d;
      6'h31: ch = 7'h7c;
      6'h33: ch = 7'h3a;
      6'h34: ch = 7'h22;
      6'h35: ch = 7'h7e;
      6'h36: ch = 7'h3c;
      6'h37: ch = 7'h3e;
      6'h38: ch = 7'h3f;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] pad_lookup(input logic [4:0] idx);
    logic [6:0] ch;
    case (idx)
      5'd0:  ch = 7'h2f;
      5'd1:  ch = 7'h2a;
      5'd2:  ch = 7'h2d;
      5'd3:  ch = 7'h2b;
      5'd4:  ch = 7'h0a;
      5'd5:  ch = 7'h31;
      5'd6:  ch = 7'h32;
      5'd7:  ch = 7'h33;
      5'd8:  ch = 7'h34;
      5'd9:  ch = 7'h35;
      5'd10: ch = 7'h36;
      5'd11: ch = 7'h37;
      5'd12: ch = 7'h38;
      5'd13: ch = 7'h39;
      5'd14: ch = 7'h30;
      5'd15: ch = 7'h2e;
      5'd19: ch = 7'h3d;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] map_key(input logic [7:0] code, input logic shift,
                                         input logic caps_on);
    logic [6:0] ch;
    if (code >= KC_A && code <= KC_Z) begin
      if (shift ^ caps_on) begin
        ch = ASCII_UPPER_A + 7'(code - KC_A);
      end else begin
        ch = ASCII_LOWER_A + 7'(code - KC_A);
      end
    end else if (code >= PAD_FIRST && code <= PAD_LAST) begin
      ch = pad_lookup(5'(code - PAD_FIRST));
    end else if (code < KC_CAPS) begin
      ch = shift ? shift_lookup(code[5:0]) : plain_lookup(code[5:0]);
    end else begin
      ch = 7'h00;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: sv/hid_keyboard_report_to_ascii.sv
// channel  handshake                    beat
// report   report_valid / report_stall  report_t: type, length, modifiers, six keys
// ascii    ascii_valid / ascii_stall    ascii_t: out_char, last_of_report
//
// the front compares each report taken against the held keys and
// queues its characters, so reports follow back to back while the queue has room
// the back emits one character per cycle while not stalled, 0 to 18 per report; reports
// with nothing to emit bypass the queue; queue depth sets how far the front runs ahead
// reset clears held keys, caps lock, the queue and the output valid flag
// ascii_stall holds the output beat; report_stall rises only when the queue is full
`timescale 1ns / 1ps
`default_nettype none

module hid_keyboard_report_to_ascii import hkra_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    report_valid,
  output logic         report_stall,
  input  wire report_t report,
  output logic         ascii_valid,
  input  wire logic    ascii_stall,
  output ascii_t       ascii
);

  logic   full;
  logic   push;
  entry_t push_data;
  logic   pop;
  logic   head_valid;
  entry_t head;

  hkra_front u_front (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .full         (full),
    .push         (push),
    .push_data    (push_data)
  );

  hkra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  hkra_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .ascii_valid (ascii_valid),
    .ascii_stall (ascii_stall),
    .ascii       (ascii)
  );

endmodule

`default_nettype wire

// File: sv/hkra_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hkra_front import hkra_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    report_valid,
  output logic         report_stall,
  input  wire report_t report,
  input  wire logic    full,
  output logic         push,
  output entry_t       push_data
);

  logic [7:0] held [NUM_SLOTS];
  logic       caps;
  logic       caps_next;

  logic [7:0]           keys [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] is_new;
  logic [NUM_SLOTS-1:0] slot_caps;
  logic                 shift;
  logic                 kbd_ok;
  logic                 take;
  logic                 hit;
  logic [6:0]           mapped;
  logic                 any_tok;

  assign keys[0] = report.key_0;
  assign keys[1] = report.key_1;
  assign keys[2] = report.key_2;
  assign keys[3] = report.key_3;
  assign keys[4] = report.key_4;
  assign keys[5] = report.key_5;

  assign shift        = (report.modifiers & SHIFT_BITS) != 8'h00;
  assign kbd_ok       = (report.device_type == KBD_TYPE) && (report.report_length == KBD_LEN);
  assign report_stall = full;
  assign take         = report_valid && !full && kbd_ok;

  // new-key detection against the last report taken
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        hit = hit | (held[j] == keys[i]);
      end
      is_new[i] = (keys[i] != 8'h00) && !hit;
    end
  end

  // caps state seen by each slot, in slot order
  always_comb begin
    caps_next = caps;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_caps[i] = caps_next;
      if (is_new[i] && keys[i] == KC_CAPS) begin
        caps_next = ~caps_next;
      end
    end
  end

  always_comb begin
    push_data = '0;
    mapped    = 7'h00;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      mapped = map_key(keys[i], shift, slot_caps[i]);
      push_data.toks[i].kind = TOK_NONE;
      push_data.toks[i].ch   = mapped;
      if (is_new[i]) begin
        case (keys[i])
          KC_CAPS: push_data.toks[i].kind = TOK_NONE;
          KC_BKSP: push_data.toks[i].kind = TOK_BS;
          KC_RIGHT: begin
            push_data.toks[i].kind = TOK_ESC;
            push_data.toks[i].ch   = ASCII_ARROW_R;
          end
          KC_LEFT: begin
            push_data.toks[i].kind = TOK_ESC;
            push_data.toks[i].ch   = ASCII_ARROW_L;
          end
          KC_DOWN: begin
            push_data.toks[i].kind = TOK_ESC;
            push_data.toks[i].ch   = ASCII_ARROW_D;
          end
          KC_UP: begin
            push_data.toks[i].kind = TOK_ESC;
            push_data.toks[i].ch   = ASCII_ARROW_U;
          end
          default: begin
            push_data.toks[i].kind = (mapped != 7'h00) ? TOK_CHAR : TOK_NONE;
          end
        endcase
      end
    end
  end

  always_comb begin
    any_tok = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      any_tok = any_tok | (push_data.toks[i].kind != TOK_NONE);
    end
  end

  // reports with nothing to emit never reach the queue
  assign push = take && any_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      caps <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        held[i] <= 8'h00;
      end
    end else if (take) begin
      caps <= caps_next;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        held[i] <= keys[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/hkra_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hkra_queue import hkra_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/hkra_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hkra_back import hkra_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire entry_t head,
  output logic        pop,
  output logic        ascii_valid,
  input  wire logic   ascii_stall,
  output ascii_t      ascii
);

  logic [NUM_SLOTS-1:0] done;
  logic [NUM_SLOTS-1:0] done_next;
  logic [1:0]           sub;
  logic [1:0]           sub_next;

  logic [NUM_SLOTS-1:0] pending;
  logic [NUM_SLOTS-1:0] cur;
  slot_tok_t            tok;
  logic                 load;
  logic                 slot_end;
  logic                 last;
  logic [6:0]           ch;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pending[i] = head_valid && (head.toks[i].kind != TOK_NONE) && !done[i];
    end
  end

  // lowest pending slot
  always_comb begin
    cur = '0;
    tok = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        cur    = '0;
        cur[i] = 1'b1;
        tok    = head.toks[i];
      end
    end
  end

  always_comb begin
    case (tok.kind)
      TOK_BS:  ch = (sub == SEQ_MID) ? ASCII_SP : ASCII_BS;
      TOK_ESC: begin
        case (sub)
          2'd0:    ch = ASCII_ESC;
          SEQ_MID: ch = ASCII_LBRACK;
          default: ch = tok.ch;
        endcase
      end
      default: ch = tok.ch;
    endcase
  end

  assign load     = head_valid && (!ascii_valid || !ascii_stall);
  assign slot_end = (tok.kind == TOK_CHAR) || (sub == SEQ_LAST);
  assign last     = slot_end && ((pending & ~cur) == '0);
  assign pop      = load && last;

  always_comb begin
    done_next = done;
    sub_next  = sub;
    if (load) begin
      if (last) begin
        done_next = '0;
        sub_next  = 2'd0;
      end else if (slot_end) begin
        done_next = done | cur;
        sub_next  = 2'd0;
      end else begin
        sub_next = sub + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= '0;
      sub         <= 2'd0;
      ascii_valid <= 1'b0;
    end else begin
      done        <= done_next;
      sub         <= sub_next;
      ascii_valid <= load || (ascii_valid && ascii_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ascii.out_char       <= ch;
      ascii.last_of_report <= last;
    end
  end

endmodule

`default_nettype wire

// File: sv/hkra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hid_keyboard_report_to_ascii_macros.svh"

module hkra_checker import hkra_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    report_stall,
  input wire logic    ascii_valid,
  input wire logic    ascii_stall,
  input wire ascii_t  ascii
);

  logic held_beat;

  assign held_beat = ascii_valid && ascii_stall;

  // a held beat stays put
  `HKRA_ASSERT(a_hold, clk, rst, held_beat |=> ascii_valid && $stable(ascii), "held beat moved")

  // a zero code is never emitted
  `HKRA_ASSERT(a_nonzero, clk, rst, ascii_valid |-> ascii.out_char != 7'h00, "zero char emitted")

  `HKRA_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !ascii_valid, "output valid right after reset")

  `HKRA_ASSERT_ALWAYS(a_rst_in, clk, rst |=> !report_stall, "input stalled right after reset")

endmodule

bind hid_keyboard_report_to_ascii hkra_checker u_hkra_checker (.*);

`default_nettype wire

// File: sim/hid_keyboard_report_to_ascii_test.sv
`timescale 1ns / 1ps

module hid_keyboard_report_to_ascii_test;
  import hkra_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_KBD   = 230;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] MOD_LSHIFT = 8'h02;
  localparam logic [7:0] MOD_RSHIFT = 8'h20;

  // characters written out by hand for a directed row
  typedef struct packed {
    logic             typed;
    logic [1:0]       cnt;
    logic [2:0][6:0]  chars;
  } hand_exp_t;

  typedef struct packed {
    report_t   rep;
    hand_exp_t hand;
  } dir_row_t;

  localparam hand_exp_t NO_HAND = '0;

  logic    clk;
  logic    rst;
  logic    report_valid;
  logic    report_stall;
  report_t report;
  logic    ascii_valid;
  logic    ascii_stall;
  ascii_t  ascii;

  hid_keyboard_report_to_ascii dut (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .ascii_valid  (ascii_valid),
    .ascii_stall  (ascii_stall),
    .ascii        (ascii)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // lookup tables for the non-letter keys
  logic [7:0] shift_digits [10] = '{"!", "@", "#", "$", "%", "^", "&", "*", "(", ")"};
  logic [7:0] plain_punct [17] = '{8'h0a, 8'h1b, 8'h08, 8'h09, 8'h20, "-", "=", "[", "]",
                                   "\\", 8'h00, ";", "'", 8'h60, ",", ".", "/"};
  logic [7:0] shift_punct [17] = '{8'h0a, 8'h1b, 8'h08, 8'h09, 8'h20, "_", "+", "{", "}",
                                   "|", 8'h00, ":", "\"", "~", "<", ">", "?"};
  logic [7:0] pad_chars [20] = '{"/", "*", "-", "+", 8'h0a, "1", "2", "3", "4", "5", "6",
                                 "7", "8", "9", "0", ".", 8'h00, 8'h00, 8'h00, "="};
  logic [7:0] special_keys [6] = '{KC_CAPS, KC_BKSP, KC_RIGHT, KC_LEFT, KC_DOWN, KC_UP};

  // keyboard state mirror
  logic [7:0] held [6];
  logic       caps_on;
  logic [6:0] new_chars [$];
  ascii_t     char_q [$];
  hand_exp_t  hand_q [$];

  hand_exp_t cur_hand;
  ascii_t    want;
  int        errors;
  int        cycles;
  int        chars_seen;
  int        full_stall_cycles;
  int        reports_sent;
  int        reports_ignored;
  logic [7:0] prev_keys [6];
  dir_row_t  dir_tab [24];

  function automatic hand_exp_t hand(input int cnt, input logic [6:0] c0, input logic [6:0] c1,
                                     input logic [6:0] c2);
    return {1'b1, 2'(cnt), c0, c1, c2};
  endfunction

  function automatic logic [6:0] key_char(input logic [7:0] code, input logic shifted);
    logic [7:0] ch;
    ch = 8'h00;
    if (code >= KC_A && code <= KC_Z)
      ch = {1'b0, (shifted ^ caps_on) ? ASCII_UPPER_A : ASCII_LOWER_A} + (code - KC_A);
    else if (code >= 8'h1e && code <= 8'h27)
      ch = shifted ? shift_digits[code - 8'h1e]
                   : ((code == 8'h27) ? 8'h30 : 8'h31 + (code - 8'h1e));
    else if (code >= 8'h28 && code <= 8'h38)
      ch = shifted ? shift_punct[code - 8'h28] : plain_punct[code - 8'h28];
    else if (code >= PAD_FIRST && code <= PAD_LAST)
      ch = pad_chars[code - PAD_FIRST];
    return ch[6:0];
  endfunction

  function automatic void push_arrow(input logic [6:0] dir);
    new_chars.push_back(ASCII_ESC);
    new_chars.push_back(ASCII_LBRACK);
    new_chars.push_back(dir);
  endfunction

  // fills new_chars with what one report produces and updates the key state
  function automatic void decode_report(input report_t r);
    logic [7:0] keys [6];
    logic [7:0] k;
    logic [6:0] ch;
    logic       shifted;
    logic       seen;
    new_chars.delete();
    if (r.device_type != KBD_TYPE || r.report_length != KBD_LEN)
      return;
    keys = '{r.key_0, r.key_1, r.key_2, r.key_3, r.key_4, r.key_5};
    shifted = (r.modifiers & SHIFT_BITS) != 8'h00;
    for (int i = 0; i < 6; i++) begin
      k = keys[i];
      seen = 1'b0;
      for (int j = 0; j < 6; j++)
        if (held[j] == k)
          seen = 1'b1;
      if (k != 8'h00 && !seen) begin
        case (k)
          KC_CAPS: caps_on = !caps_on;
          KC_BKSP: begin
            new_chars.push_back(ASCII_BS);
            new_chars.push_back(ASCII_SP);
            new_chars.push_back(ASCII_BS);
          end
          KC_RIGHT: push_arrow(ASCII_ARROW_R);
          KC_LEFT:  push_arrow(ASCII_ARROW_L);
          KC_DOWN:  push_arrow(ASCII_ARROW_D);
          KC_UP:    push_arrow(ASCII_ARROW_U);
          default: begin
            ch = key_char(k, shifted);
            if (ch != 7'h00)
              new_chars.push_back(ch);
          end
        endcase
      end
    end
    held = keys;
  endfunction

  function automatic logic [7:0] pick_key(input int slot);
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3:       return prev_keys[slot];
      4, 5:    return 8'($urandom_range(KC_A, KC_Z));
      6:       return 8'($urandom_range(8'h1e, 8'h38));
      7:       return special_keys[$urandom_range(0, 5)];
      8:       return 8'($urandom_range(PAD_FIRST, PAD_LAST));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_report(input report_t r, input hand_exp_t h);
    int gap;
    gap = ((reports_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      report_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    report_valid <= 1'b1;
    report <= r;
    hand_q.push_back(h);
    reports_sent++;
    do @(posedge clk); while (report_stall);
  endtask

  // scoreboard: predict on every accepted report, compare every accepted character
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still due", cycles, char_q.size());
      $display("Verification failed");
      $finish;
    end
    if (!rst) begin
      if (report_valid && report_stall)
        full_stall_cycles++;
      if (report_valid && !report_stall) begin
        cur_hand = hand_q.pop_front();
        decode_report(report);
        if (cur_hand.typed) begin
          for (int i = 0; i < cur_hand.cnt; i++)
            char_q.push_back({cur_hand.chars[2 - i], i == int'(cur_hand.cnt) - 1});
        end else begin
          foreach (new_chars[i])
            char_q.push_back({new_chars[i], i == new_chars.size() - 1});
        end
      end
      if (ascii_valid && !ascii_stall) begin
        chars_seen++;
        if (char_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected beat: char %h last %b", ascii.out_char, ascii.last_of_report);
          errors++;
        end else begin
          want = char_q.pop_front();
          if (ascii.out_char !== want.out_char ||
              ascii.last_of_report !== want.last_of_report) begin
            if (errors < 10)
              $display("beat %0d: expected char %h last %b, got char %h last %b", chars_seen,
                       want.out_char, want.last_of_report, ascii.out_char,
                       ascii.last_of_report);
            errors++;
          end
        end
      end
    end
  end

  // output side: random stalls, quiet stretches, one long hold-off
  initial begin
    int pause;
    logic held_off;
    ascii_stall = 1'b0;
    held_off = 1'b0;
    wait (!rst);
    forever begin
      if (!held_off && chars_seen >= 80) begin
        held_off = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          ascii_stall <= 1'b1;
        end
      end
      pause = ((chars_seen / 50) % 4 == 2) ? 0 : $urandom_range(0, 7);
      repeat (pause) begin
        @(negedge clk);
        ascii_stall <= 1'b1;
      end
      @(negedge clk);
      ascii_stall <= 1'b0;
      do @(posedge clk); while (!ascii_valid);
    end
  end

  initial begin
    report_t r;
    int kbd_random;
    rst = 1'b1;
    report_valid = 1'b0;
    report = '0;
    caps_on = 1'b0;
    errors = 0;
    cycles = 0;
    chars_seen = 0;
    full_stall_cycles = 0;
    reports_sent = 0;
    reports_ignored = 0;
    kbd_random = 0;
    foreach (held[i]) held[i] = 8'h00;
    foreach (prev_keys[i]) prev_keys[i] = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dir_tab = '{
      {KBD_TYPE, KBD_LEN, 8'h00, KC_A, 40'h0, hand(1, 7'h61, 7'h00, 7'h00)},
      // key still held: nothing
      {KBD_TYPE, KBD_LEN, SHIFT_BITS, KC_A, 40'h0, hand(0, 7'h00, 7'h00, 7'h00)},
      {KBD_TYPE, KBD_LEN, MOD_LSHIFT, KC_Z, 40'h0, hand(1, 7'h5a, 7'h00, 7'h00)},
      {KBD_TYPE, KBD_LEN, MOD_RSHIFT, KC_A, 8'h05, 32'h0, hand(2, 7'h41, 7'h42, 7'h00)},
      // rejected reports leave the state alone
      {8'h07, KBD_LEN, 8'h00, 8'h06, 40'h0, hand(0, 7'h00, 7'h00, 7'h00)},
      {KBD_TYPE, 8'h07, 8'h00, 8'h06, 40'h0, hand(0, 7'h00, 7'h00, 7'h00)},
      {8'hff, 8'hff, 8'hff, 48'hffff_ffff_ffff, hand(0, 7'h00, 7'h00, 7'h00)},
      {8'h00, 8'h00, 8'h00, 48'h0, hand(0, 7'h00, 7'h00, 7'h00)},
      {KBD_TYPE, KBD_LEN, 8'h00, 48'h0, hand(0, 7'h00, 7'h00, 7'h00)},
      {KBD_TYPE, KBD_LEN, 8'h00, KC_BKSP, 40'h0, hand(3, ASCII_BS, ASCII_SP, ASCII_BS)},
      {KBD_TYPE, KBD_LEN, 8'h00, KC_RIGHT, KC_LEFT, KC_DOWN, KC_UP, 16'h0, NO_HAND},
      {KBD_TYPE, KBD_LEN, 8'h00, 48'h0, hand(0, 7'h00, 7'h00, 7'h00)},
      // caps lock on, then shift undoes it for letters
      {KBD_TYPE, KBD_LEN, 8'h00, KC_CAPS, KC_A, 32'h0, hand(1, 7'h41, 7'h00, 7'h00)},
      {KBD_TYPE, KBD_LEN, SHIFT_BITS, 8'h05, 40'h0, hand(1, 7'h62, 7'h00, 7'h00)},
      {KBD_TYPE, KBD_LEN, 8'h00, KC_CAPS, 40'h0, hand(0, 7'h00, 7'h00, 7'h00)},
      // same new key in several slots
      {KBD_TYPE, KBD_LEN, 8'h00, 8'h1e, 8'h1e, 8'h1e, 24'h0, hand(3, 7'h31, 7'h31, 7'h31)},
      // codes with no mapping
      {KBD_TYPE, KBD_LEN, 8'h00, 8'hff, 8'h68, 8'h53, 8'h32, 8'h01, 8'h00,
       hand(0, 7'h00, 7'h00, 7'h00)},
      {KBD_TYPE, KBD_LEN, 8'hff, PAD_FIRST, PAD_LAST, 8'h65, 8'h66, 8'h5f, 8'h62, NO_HAND},
      // longest burst a report can cause
      {KBD_TYPE, KBD_LEN, 8'h00, KC_BKSP, KC_RIGHT, KC_LEFT, KC_DOWN, KC_UP, KC_BKSP, NO_HAND},
      {KBD_TYPE, KBD_LEN, SHIFT_BITS, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31, 8'h38, NO_HAND},
      {KBD_TYPE, KBD_LEN, 8'h00, 8'h28, 8'h29, 8'h2b, 8'h2c, 8'h33, 8'h34, NO_HAND},
      {KBD_TYPE, KBD_LEN, SHIFT_BITS, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, NO_HAND},
      {KBD_TYPE, KBD_LEN, 8'h00, 8'h35, 8'h36, 8'h37, 8'h24, 8'h25, 8'h26, NO_HAND},
      {KBD_TYPE, KBD_LEN, MOD_RSHIFT, 8'h27, 8'h56, 8'h57, 8'h58, 8'h55, 8'h5b, NO_HAND}
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].rep.device_type != KBD_TYPE || dir_tab[i].rep.report_length != KBD_LEN)
        reports_ignored++;
      send_report(dir_tab[i].rep, dir_tab[i].hand);
    end
    prev_keys = '{dir_tab[23].rep.key_0, dir_tab[23].rep.key_1, dir_tab[23].rep.key_2,
                  dir_tab[23].rep.key_3, dir_tab[23].rep.key_4, dir_tab[23].rep.key_5};

    while (kbd_random < RANDOM_KBD) begin
      r = {KBD_TYPE, KBD_LEN,
           ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
           pick_key(0), pick_key(1), pick_key(2), pick_key(3), pick_key(4), pick_key(5)};
      if ($urandom_range(0, 9) == 0)
        r = {KBD_TYPE, KBD_LEN, r.modifiers, prev_keys[0], prev_keys[1], prev_keys[2],
             prev_keys[3], prev_keys[4], prev_keys[5]};
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 2))
          0: r.device_type = 8'($urandom_range(0, 255));
          1: r.report_length = 8'($urandom_range(0, 255));
          default: begin
            r.device_type = 8'($urandom_range(0, 255));
            r.report_length = 8'($urandom_range(0, 255));
          end
        endcase
      end
      if (r.device_type == KBD_TYPE && r.report_length == KBD_LEN) begin
        kbd_random++;
        prev_keys = '{r.key_0, r.key_1, r.key_2, r.key_3, r.key_4, r.key_5};
      end else begin
        reports_ignored++;
      end
      send_report(r, NO_HAND);
    end
    @(negedge clk);
    report_valid <= 1'b0;

    while (char_q.size() != 0 || hand_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (char_q.size() != 0) begin
      $display("%0d characters never arrived", char_q.size());
      errors++;
    end

    $display("%0d reports sent, %0d not from a keyboard or of wrong length, %0d chars checked",
             reports_sent, reports_ignored, chars_seen);
    $display("input held off for %0d cycles by a full queue, %0d mismatches",
             full_stall_cycles, errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
